/* design/nae_pkg.sv */
package nae_pkg;

    localparam int HIDDEN      = 256;
    localparam int HW          = $clog2(HIDDEN);
    localparam int OW          = $clog2(2 * HIDDEN);
    localparam int PIECE_KINDS = 6;
    localparam int ROW_W       = $clog2(2 * PIECE_KINDS * 64);
    localparam int FW_DEPTH    = 2 * PIECE_KINDS * 64 * HIDDEN;
    localparam int FA_W        = $clog2(FW_DEPTH);
    localparam int QA          = 255;
    localparam int QB          = 64;
    localparam int QB_SH       = $clog2(QB);
    localparam int SCALE_MUL   = 400;
    localparam int SUM_W       = 48;
    localparam int N_DIG       = SUM_W / 8;
    localparam int DCNT_W      = $clog2(N_DIG);

    localparam logic [5:0]             RANK_FLIP = 6'b111000;
    localparam logic signed [9:0]      SCALE_K   = 10'(SCALE_MUL);
    localparam logic signed [SUM_W-1:0] S32_MAX  = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] S32_MIN  = SUM_W'(-64'sd2147483648);

    typedef enum logic [2:0] {
        M_LD_FW   = 3'd0,
        M_LD_BIAS = 3'd1,
        M_LD_OW   = 3'd2,
        M_RESET   = 3'd3,
        M_ADD     = 3'd4,
        M_REMOVE  = 3'd5,
        M_MOVE    = 3'd6,
        M_EVAL    = 3'd7
    } t_mode;

    typedef struct packed {
        logic capture;
        logic load;
        logic setup;
        logic use_to;
        logic sub;
        logic cnt_inc;
        logic rd_p0;
        logic wr_p1;
        logic wr_tail;
        logic eval_rd;
        logic div1_start;
        logic scale;
        logic div2_start;
        logic fin;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  piece_ok;
        logic  last_upd;
        logic  last_eval;
        logic  pipe_busy;
        logic  div_done;
    } t_stat;

    function automatic logic [FA_W-1:0] row_base(input logic colour, input logic [2:0] pt,
                                                 input logic [5:0] sq);
        logic [ROW_W-1:0] r;
        r = (ROW_W'(colour) * ROW_W'(PIECE_KINDS) + ROW_W'(pt)) * ROW_W'(64) + ROW_W'(sq);
        return FA_W'(r) * FA_W'(HIDDEN);
    endfunction

endpackage

/* design/nae_div.sv */
module nae_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [nae_pkg::SUM_W-1:0] i_dividend,
    input  logic                             i_by_qb,
    output logic                             o_done,
    output logic signed [nae_pkg::SUM_W-1:0] o_quo
);
    import nae_pkg::*;

    logic                r_busy, r_done, r_neg, r_by_qb;
    logic [DCNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]    r_quo;
    logic [7:0]          r_rem;
    logic [15:0]         part;
    logic [16:0]         est;
    logic [7:0]          qdig;
    logic [7:0]          n_rem;
    logic [SUM_W-1:0]    mag;

    // Division by 255 on the magnitude, one byte per cycle. The remainder stays
    // below 255, so each partial value is below 255*256, where (v + 1 + v/256)/256
    // is exactly v/255. The sign is applied at the end so the result truncates
    // toward zero. Dividing the quotient by 64 afterwards gives the division by
    // 255*64.
    assign part  = {r_rem, r_quo[SUM_W-1 -: 8]};
    assign est   = 17'(part) + 17'd1 + 17'(part[15:8]);
    assign qdig  = est[15:8];
    assign n_rem = 8'(part - {qdig, 8'd0} + 16'(qdig));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_by_qb <= i_by_qb;
                r_neg   <= i_dividend < 0;
                r_quo   <= (i_dividend < 0) ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[SUM_W-9:0], qdig};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(N_DIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign mag    = r_by_qb ? (r_quo >> QB_SH) : r_quo;
    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(mag) : $signed(mag);

endmodule

/* design/nae_dp.sv */
module nae_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  nae_pkg::t_cmd         i_cmd,
    output nae_pkg::t_stat        o_stat,
    input  logic [2:0]            i_mode,
    input  logic                  i_colour,
    input  logic [2:0]            i_piece,
    input  logic [5:0]            i_from_square,
    input  logic [5:0]            i_to_square,
    input  logic [8:0]            i_index,
    input  logic signed [15:0]    i_value,
    input  logic                  i_side_to_move,
    input  logic                  i_output_bias_we,
    input  logic signed [15:0]    i_output_bias,
    output logic signed [31:0]    o_score
);
    import nae_pkg::*;

    logic [15:0] fw_mem   [FW_DEPTH];
    logic [15:0] bias_mem [HIDDEN];
    logic [15:0] ow_mem   [2*HIDDEN];
    logic [15:0] acc0_mem [HIDDEN];
    logic [15:0] acc1_mem [HIDDEN];

    t_mode              r_mode;
    logic               r_colour, r_stm;
    logic [2:0]         r_piece;
    logic [5:0]         r_from, r_to;
    logic [8:0]         r_index;
    logic [15:0]        r_value;
    logic signed [15:0] r_bias;

    logic [FA_W-1:0]    r_wbase, r_bbase;
    logic [OW-1:0]      r_cnt;
    logic [HW-1:0]      r_prev;
    logic               r_pend, r_sub, r_rst_op;

    logic [15:0]        r_fw_q, r_bias_q, r_ow_q, r_acc0_q, r_acc1_q;

    logic               r_v1, r_v2, r_v3, r_sel1;
    logic [15:0]        r_sq;
    logic signed [15:0] r_w;
    logic signed [32:0] r_prod;
    logic signed [SUM_W-1:0] r_sum, r_scaled, r_res;
    logic signed [31:0] r_score;

    logic               piece_ok;
    logic [2:0]         pt;
    logic [5:0]         sq;
    logic [HW-1:0]      ent, ea;
    logic               lo_half;
    logic               acc_re, fw_re, fw_we, bias_we, ow_we, acc1_we;
    logic [FA_W-1:0]    fw_raddr, fw_waddr;
    logic [HW-1:0]      acc1_waddr;
    logic [15:0]        acc0_wdata, acc1_wdata;
    logic signed [15:0] sel_acc;
    logic [7:0]         clamped;
    logic               div_start, div_sel, div_done;
    logic signed [SUM_W-1:0] div_q, scale_t;

    assign piece_ok = r_piece >= 3'd1 && r_piece <= 3'(PIECE_KINDS);
    assign pt       = piece_ok ? r_piece - 3'd1 : 3'd0;
    assign sq       = i_cmd.use_to ? r_to : r_from;
    assign ent      = HW'(r_cnt);
    assign lo_half  = r_cnt < OW'(HIDDEN);
    assign ea       = lo_half ? HW'(r_cnt) : HW'(r_cnt - OW'(HIDDEN));

    assign fw_we    = i_cmd.load && r_mode == M_LD_FW && piece_ok && 32'(r_index) < HIDDEN;
    assign bias_we  = i_cmd.load && r_mode == M_LD_BIAS && 32'(r_index) < HIDDEN;
    assign ow_we    = i_cmd.load && r_mode == M_LD_OW && 32'(r_index) < 2 * HIDDEN;
    assign fw_waddr = row_base(r_colour, pt, r_from) + FA_W'(r_index);
    assign fw_re    = i_cmd.rd_p0 || i_cmd.wr_p1;
    assign fw_raddr = (i_cmd.rd_p0 ? r_wbase : r_bbase) + FA_W'(ent);
    assign acc_re   = i_cmd.rd_p0 || i_cmd.eval_rd;

    // The white sum is written in the second phase of an entry, the black sum of a
    // non-reset one phase later, once its row has come out of the shared memory.
    assign acc0_wdata = r_rst_op ? r_bias_q : (r_sub ? r_acc0_q - r_fw_q : r_acc0_q + r_fw_q);
    assign acc1_wdata = r_rst_op ? r_bias_q : (r_sub ? r_acc1_q - r_fw_q : r_acc1_q + r_fw_q);
    assign acc1_we    = (i_cmd.wr_p1 && r_rst_op) ||
                        ((i_cmd.rd_p0 || i_cmd.wr_tail) && r_pend);
    assign acc1_waddr = i_cmd.wr_p1 ? ent : r_prev;

    always_ff @(posedge i_clk) begin
        if (fw_we) fw_mem[fw_waddr] <= r_value;
        if (fw_re) r_fw_q <= fw_mem[fw_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bias_we) bias_mem[HW'(r_index)] <= r_value;
        if (i_cmd.rd_p0) r_bias_q <= bias_mem[ent];
    end

    always_ff @(posedge i_clk) begin
        if (ow_we) ow_mem[OW'(r_index)] <= r_value;
        if (i_cmd.eval_rd) r_ow_q <= ow_mem[r_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_p1) acc0_mem[ent] <= acc0_wdata;
        if (acc_re) r_acc0_q <= acc0_mem[i_cmd.eval_rd ? ea : ent];
    end

    always_ff @(posedge i_clk) begin
        if (acc1_we) acc1_mem[acc1_waddr] <= acc1_wdata;
        if (acc_re) r_acc1_q <= acc1_mem[i_cmd.eval_rd ? ea : ent];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0;
        end else if (i_output_bias_we) begin
            r_bias <= i_output_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= t_mode'(i_mode);
            r_colour <= i_colour;
            r_piece  <= i_piece;
            r_from   <= i_from_square;
            r_to     <= i_to_square;
            r_index  <= i_index;
            r_value  <= i_value;
            r_stm    <= i_side_to_move;
        end
        if (i_cmd.setup) begin
            r_wbase  <= row_base(r_colour, pt, sq ^ RANK_FLIP);
            r_bbase  <= row_base(~r_colour, pt, sq);
            r_sub    <= i_cmd.sub;
            r_rst_op <= r_mode == M_RESET;
            r_cnt    <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.wr_p1) r_prev <= ent;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.setup) begin
            r_pend <= 1'b0;
        end else if (i_cmd.wr_p1) begin
            r_pend <= !r_rst_op;
        end else if (i_cmd.rd_p0 || i_cmd.wr_tail) begin
            r_pend <= 1'b0;
        end
    end

    // Evaluate pipeline: read, SCReLU square, weight product, accumulate.
    assign sel_acc = r_sel1 ? $signed(r_acc1_q) : $signed(r_acc0_q);
    always_comb begin
        if (sel_acc < 0) begin
            clamped = 8'd0;
        end else if (sel_acc > 16'(QA)) begin
            clamped = 8'(QA);
        end else begin
            clamped = sel_acc[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.eval_rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel1 <= lo_half ? r_stm : !r_stm;
        r_sq   <= 16'(clamped) * 16'(clamped);
        r_w    <= $signed(r_ow_q);
        r_prod <= $signed({1'b0, r_sq}) * r_w;
        if (i_cmd.setup) begin
            r_sum <= '0;
        end else if (r_v3) begin
            r_sum <= r_sum + SUM_W'(r_prod);
        end
    end

    assign div_start = i_cmd.div1_start || i_cmd.div2_start;
    assign div_sel   = i_cmd.div2_start;

    nae_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_sel ? r_scaled : r_sum),
        .i_by_qb    (div_sel),
        .o_done     (div_done),
        .o_quo      (div_q)
    );

    assign scale_t = div_q + SUM_W'(r_bias);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) r_scaled <= scale_t * SCALE_K;
        if (i_cmd.fin) begin
            if (div_q > S32_MAX) begin
                r_res <= S32_MAX;
            end else if (div_q < S32_MIN) begin
                r_res <= S32_MIN;
            end else begin
                r_res <= div_q;
            end
        end
        if (i_cmd.out_load) r_score <= 32'(r_res);
    end

    assign o_score = r_score;

    assign o_stat.mode      = r_mode;
    assign o_stat.piece_ok  = piece_ok;
    assign o_stat.last_upd  = r_cnt == OW'(HIDDEN - 1);
    assign o_stat.last_eval = r_cnt == OW'(2 * HIDDEN - 1);
    assign o_stat.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_stat.div_done  = div_done;

endmodule

/* design/nae_ctrl.sv */
module nae_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  nae_pkg::t_stat  i_stat,
    output nae_pkg::t_cmd   o_cmd
);
    import nae_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECODE = 13'b0000000000010,
        S_LOAD   = 13'b0000000000100,
        S_SETUP  = 13'b0000000001000,
        S_P0     = 13'b0000000010000,
        S_P1     = 13'b0000000100000,
        S_TAIL   = 13'b0000001000000,
        S_EVAL   = 13'b0000010000000,
        S_DRAIN  = 13'b0000100000000,
        S_DIV1   = 13'b0001000000000,
        S_DIV2S  = 13'b0010000000000,
        S_DIV2   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass, n_pass;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_pass        = 1'b0;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.mode)
                    M_LD_FW, M_LD_BIAS, M_LD_OW: n_state = S_LOAD;
                    M_ADD, M_REMOVE, M_MOVE:     n_state = i_stat.piece_ok ? S_SETUP : S_IDLE;
                    default:                     n_state = S_SETUP;
                endcase
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            S_SETUP: begin
                // A move adds the destination row first, then removes the origin row.
                o_cmd.setup  = 1'b1;
                o_cmd.use_to = i_stat.mode == M_MOVE && !r_pass;
                o_cmd.sub    = i_stat.mode == M_REMOVE || (i_stat.mode == M_MOVE && r_pass);
                n_state      = (i_stat.mode == M_EVAL) ? S_EVAL : S_P0;
            end
            S_P0: begin
                o_cmd.rd_p0 = 1'b1;
                n_state     = S_P1;
            end
            S_P1: begin
                o_cmd.wr_p1 = 1'b1;
                if (i_stat.last_upd) begin
                    n_state = (i_stat.mode == M_RESET) ? S_IDLE : S_TAIL;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_P0;
                end
            end
            S_TAIL: begin
                o_cmd.wr_tail = 1'b1;
                if (i_stat.mode == M_MOVE && !r_pass) begin
                    n_pass  = 1'b1;
                    n_state = S_SETUP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EVAL: begin
                o_cmd.eval_rd = 1'b1;
                if (i_stat.last_eval) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    o_cmd.div1_start = 1'b1;
                    n_state          = S_DIV1;
                end
            end
            S_DIV1: begin
                if (i_stat.div_done) begin
                    o_cmd.scale = 1'b1;
                    n_state     = S_DIV2S;
                end
            end
            S_DIV2S: begin
                o_cmd.div2_start = 1'b1;
                n_state          = S_DIV2;
            end
            S_DIV2: begin
                if (i_stat.div_done) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/nnue_accumulator_evaluator_unit.sv */
// NNUE evaluator with two perspective accumulators of HIDDEN 16-bit sums and
// on-chip weight memories filled by the load modes. One item is handled at a
// time, through one read port of the feature weight memory and one shared
// multiply-accumulate pipe. A reset, an add or a remove takes two memory phases
// per accumulator entry; an add, remove or move with a bad piece type is dropped
// after decoding. Evaluate walks all 2*HIDDEN entries at one per cycle, drains a
// three-stage pipe and runs two divisions. A score item waits in the output
// register while the next item is already accepted; a second score holds the
// block until the first one is taken.
module nnue_accumulator_evaluator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic               i_colour,
    input  logic [2:0]         i_piece,
    input  logic [5:0]         i_from_square,
    input  logic [5:0]         i_to_square,
    input  logic [8:0]         i_index,
    input  logic signed [15:0] i_value,
    input  logic               i_side_to_move,
    input  logic               i_output_bias_we,
    input  logic signed [15:0] i_output_bias,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_score
);
    import nae_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    nae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    nae_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_mode           (i_mode),
        .i_colour         (i_colour),
        .i_piece          (i_piece),
        .i_from_square    (i_from_square),
        .i_to_square      (i_to_square),
        .i_index          (i_index),
        .i_value          (i_value),
        .i_side_to_move   (i_side_to_move),
        .i_output_bias_we (i_output_bias_we),
        .i_output_bias    (i_output_bias),
        .o_score          (o_score)
    );

endmodule
